### rtl/nups_pkg.sv
// Shared types and constants for the nearest unvisited point search block.
// No dependencies; imported by every module of the block.
package nups_pkg;

    localparam int ACT_W  = 3;   // action code width
    localparam int STAT_W = 3;   // status code width
    localparam int IDX_W  = 10;  // index field width on the stream ports
    localparam int CNT_W  = 11;  // entry count field width on the stream ports

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 3'd0,
        ACT_APPEND = 3'd1,
        ACT_MARK   = 3'd2,
        ACT_QUERY  = 3'd3,
        ACT_FETCH  = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_VISITED = 3'd1,
        STAT_RANGE   = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_EMPTY   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_READ,
        S_LOAD,
        S_OUT
    } t_state;

    // write controls for the point store
    typedef struct packed {
        logic we_pt;   // write coordinates
        logic we_vis;  // write visited mark
        logic vis;     // visited mark value
    } t_wr_ctl;

endpackage

### rtl/nearest_unvisited_point_search.sv
// Nearest unvisited point search: a table of up to MAX_POINTS signed 2-D points with visited
// marks, driven by one command per input transfer (clear, append, mark visited, query nearest,
// fetch by index) and answering each with exactly one output transfer. The block handles one
// command at a time and drops s_axis_tready while it works. Clear, append and unused actions
// go straight to the output register, as do out-of-range marks and fetches and a query of an
// empty table; an in-range mark or fetch first does one table read. For a query the sequencer
// streams the stored points through the table's single read port, one point per cycle, into
// a 3-stage squared-distance pipeline whose result is compared against the running best;
// after the pipeline drains the winner is read back once. Distances are exact squares (no root);
// on a tie the lowest index wins. A finished result sits in the output register, so the next
// command can be taken while it waits for m_axis_tready.
// Depends on nups_pkg, nups_store and nups_dist.
module nearest_unvisited_point_search
    import nups_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input command stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata, low bit up: index[9:0], coord_x, coord_y, zero pad
    input  logic [((IDX_W+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: action[2:0]
    input  logic [ACT_W-1:0]       s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata, low bit up: point_index[9:0], point_x, point_y, point_visited,
    // entry_count[10:0], zero pad
    output logic [((IDX_W+2*COORD_BITS+1+CNT_W+7)/8)*8-1:0] m_axis_tdata,
    // tuser: status[2:0]
    output logic [STAT_W-1:0]      m_axis_tuser
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int TW    = $clog2(MAX_POINTS + 1);
    localparam int CW    = (TW > IDX_W) ? TW : IDX_W;
    localparam int DW    = 2 * COORD_BITS + 2;
    localparam int OUT_W = ((IDX_W + 2 * COORD_BITS + 1 + CNT_W + 7) / 8) * 8;

    // input unpack
    logic                         in_xfer;
    logic [ACT_W-1:0]             in_act;
    logic [IDX_W-1:0]             in_idx;
    logic signed [COORD_BITS-1:0] in_x, in_y;

    assign in_act  = s_axis_tuser;
    assign in_idx  = s_axis_tdata[IDX_W-1:0];
    assign in_x    = s_axis_tdata[IDX_W+COORD_BITS-1:IDX_W];
    assign in_y    = s_axis_tdata[IDX_W+2*COORD_BITS-1:IDX_W+COORD_BITS];
    assign in_xfer = s_axis_tvalid & s_axis_tready;

    // control state
    t_state          r_state, n_state;
    logic [TW-1:0]   r_total, n_total;
    logic            r_rd_vld, n_rd_vld;
    logic            r_m_valid, n_m_valid;

    // payload state
    logic [ACT_W-1:0]             r_act;
    logic [AW-1:0]                r_idx, n_idx;
    logic [AW-1:0]                r_scan, n_scan;
    logic [AW-1:0]                r_rd_tag;
    logic signed [COORD_BITS-1:0] r_qx, r_qy;
    logic [AW-1:0]                r_best_idx, n_best_idx;
    logic [DW-1:0]                r_best_d, n_best_d;

    // staged result
    logic [STAT_W-1:0]            r_res_status, n_res_status;
    logic                         r_res_has, n_res_has;
    logic [AW-1:0]                r_res_idx, n_res_idx;
    logic signed [COORD_BITS-1:0] r_res_x, n_res_x, r_res_y, n_res_y;
    logic                         r_res_vis, n_res_vis;

    // output register
    logic [STAT_W-1:0]            r_m_status, n_m_status;
    logic [IDX_W-1:0]             r_m_idx, n_m_idx;
    logic signed [COORD_BITS-1:0] r_m_x, n_m_x, r_m_y, n_m_y;
    logic                         r_m_vis, n_m_vis;
    logic [CNT_W-1:0]             r_m_count, n_m_count;

    // table and distance unit hookup
    t_wr_ctl                      wr_ctl;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic                         rd_vis;
    logic                         d_vld, d_busy;
    logic [AW-1:0]                d_tag;
    logic [DW-1:0]                d_dist;

    // helpers
    logic [CW-1:0] idx_ext;
    logic          idx_ok;
    logic          tbl_full, tbl_empty, scan_last;

    assign idx_ext   = CW'(in_idx);
    assign idx_ok    = idx_ext < CW'(r_total);
    assign tbl_full  = (r_total == TW'(MAX_POINTS));
    assign tbl_empty = (r_total == '0);
    assign scan_last = ((TW'(r_scan) + TW'(1)) == r_total);
    assign rd_addr   = (r_state == S_SCAN) ? r_scan : r_idx;

    // table writes happen on the accepting edge
    always_comb begin
        wr_ctl  = '0;
        wr_addr = idx_ext[AW-1:0];
        if (in_xfer && in_act == ACT_APPEND && !tbl_full) begin
            wr_ctl.we_pt  = 1'b1;
            wr_ctl.we_vis = 1'b1;
            wr_ctl.vis    = 1'b0;
            wr_addr       = r_total[AW-1:0];
        end else if (in_xfer && in_act == ACT_MARK && idx_ok) begin
            wr_ctl.we_vis = 1'b1;
            wr_ctl.vis    = 1'b1;
        end
    end

    nups_store #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_ctl  (wr_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_x    (in_x),
        .i_wr_y    (in_y),
        .i_rd_addr (rd_addr),
        .o_rd_x    (rd_x),
        .o_rd_y    (rd_y),
        .o_rd_vis  (rd_vis)
    );

    nups_dist #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld),
        .i_tag   (r_rd_tag),
        .i_px    (rd_x),
        .i_py    (rd_y),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_vld   (d_vld),
        .o_tag   (d_tag),
        .o_dist  (d_dist),
        .o_busy  (d_busy)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_total      = r_total;
        n_rd_vld     = 1'b0;
        n_m_valid    = r_m_valid & ~m_axis_tready;
        n_idx        = r_idx;
        n_scan       = r_scan;
        n_best_idx   = r_best_idx;
        n_best_d     = r_best_d;
        n_res_status = r_res_status;
        n_res_has    = r_res_has;
        n_res_idx    = r_res_idx;
        n_res_x      = r_res_x;
        n_res_y      = r_res_y;
        n_res_vis    = r_res_vis;
        n_m_status   = r_m_status;
        n_m_idx      = r_m_idx;
        n_m_x        = r_m_x;
        n_m_y        = r_m_y;
        n_m_vis      = r_m_vis;
        n_m_count    = r_m_count;

        // running minimum; strict less-than keeps the lowest index on ties
        if (d_vld && (d_tag == '0 || d_dist < r_best_d)) begin
            n_best_idx = d_tag;
            n_best_d   = d_dist;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res_status = STAT_OK;
                    n_res_has    = 1'b0;
                    n_state      = S_OUT;
                    case (in_act)
                        ACT_CLEAR: begin
                            n_total = '0;
                        end
                        ACT_APPEND: begin
                            if (tbl_full) begin
                                n_res_status = STAT_FULL;
                            end else begin
                                n_total   = r_total + TW'(1);
                                n_res_has = 1'b1;
                                n_res_idx = r_total[AW-1:0];
                                n_res_x   = in_x;
                                n_res_y   = in_y;
                                n_res_vis = 1'b0;
                            end
                        end
                        ACT_MARK, ACT_FETCH: begin
                            if (!idx_ok) begin
                                n_res_status = STAT_RANGE;
                            end else begin
                                n_idx   = idx_ext[AW-1:0];
                                n_state = S_READ;
                            end
                        end
                        ACT_QUERY: begin
                            if (tbl_empty) begin
                                n_res_status = STAT_EMPTY;
                            end else begin
                                n_scan  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_rd_vld = 1'b1;
                n_scan   = r_scan + AW'(1);
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // wait until the last distance has been compared
                if (!r_rd_vld && !d_busy) begin
                    n_idx   = r_best_idx;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_res_has    = 1'b1;
                n_res_idx    = r_idx;
                n_res_x      = rd_x;
                n_res_y      = rd_y;
                n_res_vis    = rd_vis;
                n_res_status = (r_act != ACT_MARK && rd_vis) ? STAT_VISITED : STAT_OK;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_res_status;
                    n_m_idx    = r_res_has ? IDX_W'(r_res_idx) : '0;
                    n_m_x      = r_res_has ? r_res_x : '0;
                    n_m_y      = r_res_has ? r_res_y : '0;
                    n_m_vis    = r_res_has & r_res_vis;
                    n_m_count  = CNT_W'(r_total);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_rd_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_rd_vld  <= n_rd_vld;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_act <= in_act;
            r_qx  <= in_x;
            r_qy  <= in_y;
        end
        r_idx        <= n_idx;
        r_scan       <= n_scan;
        r_rd_tag     <= r_scan;
        r_best_idx   <= n_best_idx;
        r_best_d     <= n_best_d;
        r_res_status <= n_res_status;
        r_res_has    <= n_res_has;
        r_res_idx    <= n_res_idx;
        r_res_x      <= n_res_x;
        r_res_y      <= n_res_y;
        r_res_vis    <= n_res_vis;
        r_m_status   <= n_m_status;
        r_m_idx      <= n_m_idx;
        r_m_x        <= n_m_x;
        r_m_y        <= n_m_y;
        r_m_vis      <= n_m_vis;
        r_m_count    <= n_m_count;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = OUT_W'({r_m_count, r_m_vis, r_m_y, r_m_x, r_m_idx});

endmodule

### rtl/nups_store.sv
// Point table: coordinate memory and visited-mark memory, one write port,
// one registered read port. Depends on nups_pkg.
module nups_store
    import nups_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                         i_clk,
    input  t_wr_ctl                      i_wr_ctl,
    input  logic [$clog2(MAX_POINTS)-1:0] i_wr_addr,
    input  logic signed [COORD_BITS-1:0] i_wr_x,
    input  logic signed [COORD_BITS-1:0] i_wr_y,
    input  logic [$clog2(MAX_POINTS)-1:0] i_rd_addr,
    output logic signed [COORD_BITS-1:0] o_rd_x,
    output logic signed [COORD_BITS-1:0] o_rd_y,
    output logic                         o_rd_vis
);

    logic [2*COORD_BITS-1:0] r_pt_mem  [MAX_POINTS];
    logic                    r_vis_mem [MAX_POINTS];
    logic [2*COORD_BITS-1:0] r_rd_pt;
    logic                    r_rd_vis;

    always_ff @(posedge i_clk) begin
        if (i_wr_ctl.we_pt) begin
            r_pt_mem[i_wr_addr] <= {i_wr_y, i_wr_x};
        end
        if (i_wr_ctl.we_vis) begin
            r_vis_mem[i_wr_addr] <= i_wr_ctl.vis;
        end
        r_rd_pt  <= r_pt_mem[i_rd_addr];
        r_rd_vis <= r_vis_mem[i_rd_addr];
    end

    assign o_rd_x   = r_rd_pt[COORD_BITS-1:0];
    assign o_rd_y   = r_rd_pt[2*COORD_BITS-1:COORD_BITS];
    assign o_rd_vis = r_rd_vis;

endmodule

### rtl/nups_dist.sv
// Pipelined squared-distance unit: difference, square, sum; one point per cycle.
// Three register stages, index tag carried alongside. Depends on nups_pkg.
module nups_dist
    import nups_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [$clog2(MAX_POINTS)-1:0] i_tag,
    input  logic signed [COORD_BITS-1:0]  i_px,
    input  logic signed [COORD_BITS-1:0]  i_py,
    input  logic signed [COORD_BITS-1:0]  i_qx,
    input  logic signed [COORD_BITS-1:0]  i_qy,
    output logic                          o_vld,
    output logic [$clog2(MAX_POINTS)-1:0] o_tag,
    output logic [2*COORD_BITS+1:0]       o_dist,
    output logic                          o_busy
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int DW = 2 * COORD_BITS + 2;

    logic                    r_v1, r_v2, r_v3;
    logic [AW-1:0]           r_t1, r_t2, r_t3;
    logic signed [COORD_BITS:0] r_dx, r_dy;
    logic signed [DW-1:0]    r_sqx, r_sqy;
    logic [DW-1:0]           r_sum;

    logic signed [COORD_BITS:0] n_dx, n_dy;
    logic signed [DW-1:0]    n_sqx, n_sqy;

    assign n_dx  = {i_px[COORD_BITS-1], i_px} - {i_qx[COORD_BITS-1], i_qx};
    assign n_dy  = {i_py[COORD_BITS-1], i_py} - {i_qy[COORD_BITS-1], i_qy};
    // square of a signed value is never negative
    assign n_sqx = r_dx * r_dx;
    assign n_sqy = r_dy * r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1  <= i_tag;
        r_dx  <= n_dx;
        r_dy  <= n_dy;
        r_t2  <= r_t1;
        r_sqx <= n_sqx;
        r_sqy <= n_sqy;
        r_t3  <= r_t2;
        r_sum <= $unsigned(r_sqx) + $unsigned(r_sqy);
    end

    assign o_vld  = r_v3;
    assign o_tag  = r_t3;
    assign o_dist = r_sum;
    assign o_busy = r_v1 | r_v2 | r_v3;

endmodule
